>>> hw/rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII unit.
// No dependencies; imported by the controller, the datapath and the top level.
package b2da_pkg;

  // Double dabble bits consumed per conversion cycle.
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } b2da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic at_last;
  } b2da_stat_t;

endpackage

>>> hw/rtl/binary_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII unit: controller plus datapath.
// Depends on b2da_pkg, b2da_ctrl and b2da_datapath.
//
//   channel   ports                          handshake
//   command   start, busy, value             beat taken when start && !busy
//   result    strobe, digit_char, last_digit one beat per cycle with strobe high
//
// After its beat a value occupies the unit for the double dabble conversion, four bits
// per step, then for a pass over every digit position of the widest value, leading
// zeros dropped and the rest sent most significant first.
// Reset is synchronous and returns the unit to idle; results cannot be stalled.
module binary_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_BITS-1:0]       value,
  output logic                        strobe,
  output logic [b2da_pkg::CHAR_W-1:0] digit_char,
  output logic                        last_digit
);
  import b2da_pkg::*;

  b2da_cmd_t  cmd;
  b2da_stat_t stat;

  b2da_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .strobe     (strobe),
    .last_digit (last_digit)
  );

  b2da_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (digit_char)
  );

endmodule

>>> hw/rtl/b2da_datapath.sv
// Datapath of the binary to decimal ASCII unit: double dabble registers,
// conversion step counter and digit position counter. Depends on b2da_pkg.
module b2da_datapath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [VALUE_BITS-1:0]           value,
  input  b2da_pkg::b2da_cmd_t             cmd,
  output b2da_pkg::b2da_stat_t            stat,
  output logic [b2da_pkg::CHAR_W-1:0]     digit_char
);
  import b2da_pkg::*;

  localparam int unsigned ITERS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PAD_BITS = ITERS * BITS_PER_STEP;
  // Digits of 2**VALUE_BITS - 1, using 1233/4096 as log10(2).
  localparam int unsigned MAX_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W = MAX_DIGITS * DIGIT_W;
  localparam int unsigned ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int unsigned POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [PAD_BITS-1:0] bin;
  logic [BCD_W-1:0]    bcd;
  logic [ITER_W-1:0]   iter_cnt;
  logic [POS_W-1:0]    pos;
  logic [PAD_BITS-1:0] bin_next;
  logic [BCD_W-1:0]    bcd_next;
  logic [DIGIT_W-1:0]  top_digit;

  // Four add-3-then-shift steps per cycle; the digit adjusts run in parallel.
  always_comb begin
    logic [PAD_BITS-1:0] work_bin;
    logic [BCD_W-1:0]    work_bcd;
    work_bin = bin;
    work_bcd = bcd;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (work_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
          work_bcd[d*DIGIT_W +: DIGIT_W] = work_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
        end
      end
      work_bcd = {work_bcd[BCD_W-2:0], work_bin[PAD_BITS-1]};
      work_bin = {work_bin[PAD_BITS-2:0], 1'b0};
    end
    bin_next = work_bin;
    bcd_next = work_bcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin      <= '0;
      bcd      <= '0;
      iter_cnt <= '0;
      pos      <= '0;
    end else if (cmd.load) begin
      bin      <= PAD_BITS'(value);
      bcd      <= '0;
      iter_cnt <= '0;
      pos      <= POS_W'(MAX_DIGITS - 1);
    end else if (cmd.step) begin
      bin      <= bin_next;
      bcd      <= bcd_next;
      iter_cnt <= iter_cnt + 1'b1;
    end else if (cmd.shift) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      pos <= pos - 1'b1;
    end
  end

  assign top_digit      = bcd[BCD_W-1 -: DIGIT_W];
  assign stat.conv_last = (iter_cnt == ITER_W'(ITERS - 1));
  assign stat.top_zero  = (top_digit == '0);
  assign stat.at_last   = (pos == '0);
  assign digit_char     = ASCII_ZERO + CHAR_W'(top_digit);

endmodule

>>> hw/rtl/b2da_ctrl.sv
// Controller of the binary to decimal ASCII unit: sequences load, conversion,
// leading zero skip and digit emission. Depends on b2da_pkg.
module b2da_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  b2da_pkg::b2da_stat_t stat,
  output b2da_pkg::b2da_cmd_t  cmd,
  output logic                 busy,
  output logic                 strobe,
  output logic                 last_digit
);
  import b2da_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    strobe     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Leading zeros are shifted out silently; the units digit always goes out.
        cmd.shift = 1'b1;
        if (!stat.top_zero || stat.at_last) begin
          strobe     = 1'b1;
          state_next = stat.at_last ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.shift = 1'b1;
        strobe    = 1'b1;
        if (stat.at_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state != ST_IDLE);
  assign last_digit = stat.at_last;

endmodule

>>> dv/binary_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for binary_to_decimal_ascii_unit: converts 32-bit values to
// decimal ASCII digits and checks every character beat against a local predictor.
// Depends on b2da_pkg and the unit's RTL; needs no files or arguments.
module binary_to_decimal_ascii_unit_tb;
  import b2da_pkg::*;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DEC_BASE = 10;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned RANDOM_VALUES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PROBE_COUNT = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } ascii_char_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  busy;
  logic                  strobe;
  logic [CHAR_W-1:0]     digit_char;
  logic                  last_digit;

  // Directed values; a non-empty text is the expected decimal form typed in by hand.
  logic [VALUE_BITS-1:0] probe_value [PROBE_COUNT] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd12345, 32'd65535,
    32'd65536, 32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
    32'd2147483648, 32'hAAAAAAAA, 32'h55555555, 32'd4294967294, 32'd4294967295, 32'd0
  };
  string probe_text [PROBE_COUNT] = '{
    "0", "1", "9", "10", "", "99", "100", "", "", "", "999999999", "1000000000", "",
    "", "", "", "", "4294967294", "4294967295", "0"
  };

  string       value_text_q [$];
  ascii_char_t expected_chars_q [$];
  ascii_char_t want;
  string       accepted_text;
  int unsigned fail_count = 0;
  int unsigned values_converted = 0;
  int unsigned chars_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [MAX_DIGITS:1] lengths_seen = '0;

  binary_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .strobe(strobe),
    .digit_char(digit_char),
    .last_digit(last_digit)
  );

  always #5 clk = ~clk;

  // Appends the characters of one value, from hand-typed text or from repeated division.
  function automatic void push_decimal(input logic [VALUE_BITS-1:0] v, input string text);
    logic [VALUE_BITS-1:0] rest;
    logic [3:0]            digs [$];
    byte                   b;
    ascii_char_t           c;
    int                    n;
    if (text.len() != 0) begin
      n = text.len();
      for (int i = 0; i < n; i++) begin
        b = text[i];
        c.ch = b[CHAR_W-1:0];
        c.last = (i == n - 1);
        expected_chars_q.push_back(c);
      end
    end else begin
      rest = v;
      do begin
        digs.push_front(4'(rest % DEC_BASE));
        rest = rest / DEC_BASE;
      end while (rest != 0);
      n = digs.size();
      for (int i = 0; i < n; i++) begin
        c.ch = ASCII_ZERO + CHAR_W'(digs[i]);
        c.last = (i == n - 1);
        expected_chars_q.push_back(c);
      end
    end
    if (n >= 1 && n <= MAX_DIGITS) lengths_seen[n] = 1'b1;
  endfunction

  function automatic logic [63:0] pow10(input int unsigned e);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < e; i++) p = p * DEC_BASE;
    return p;
  endfunction

  // Mixes fully random words with values spread evenly over digit counts, values
  // sitting on a power-of-ten boundary and small values from 0 to 20.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned kind;
    int unsigned ndig;
    logic [63:0] lo;
    logic [63:0] hi;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom;
    if (kind < 8) begin
      ndig = $urandom_range(1, MAX_DIGITS);
      lo = (ndig == 1) ? 64'd0 : pow10(ndig - 1);
      hi = pow10(ndig) - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return $urandom_range(hi[31:0], lo[31:0]);
    end
    if (kind == 8) begin
      hi = pow10($urandom_range(1, MAX_DIGITS - 1));
      return $urandom_range(0, 1) ? hi[31:0] : hi[31:0] - 1;
    end
    return $urandom_range(0, 20);
  endfunction

  // Presents one value and returns at the edge where its command beat is taken.
  task automatic issue(input logic [VALUE_BITS-1:0] v, input string text);
    value_text_q.push_back(text);
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender pacing: bursts of back-to-back beats separated by idle gaps.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 25);
      start <= 1'b0;
      value <= $urandom;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        accepted_text = value_text_q.pop_front();
        push_decimal(value, accepted_text);
        values_converted++;
      end
      if (strobe) begin
        if (expected_chars_q.size() == 0) begin
          $error("unexpected character beat: digit_char %0d last_digit %0b",
                 digit_char, last_digit);
          fail_count++;
        end else begin
          want = expected_chars_q.pop_front();
          chars_checked++;
          if (digit_char !== want.ch) begin
            $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
            fail_count++;
          end
          if (last_digit !== want.last) begin
            $error("last_digit: expected %0b, got %0b", want.last, last_digit);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $error("no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = PROBE_COUNT;
    for (int i = 0; i < PROBE_COUNT; i++) begin
      issue(probe_value[i], probe_text[i]);
      pace();
    end
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      issue(pick_value(), "");
      pace();
    end
    start <= 1'b0;
    @(posedge clk);
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d values into %0d checked characters.", values_converted,
             chars_checked);
    $display("Digit counts seen, bit n for n digits: %b", lengths_seen);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_datapath.sv
hw/rtl/b2da_ctrl.sv
hw/rtl/binary_to_decimal_ascii_unit.sv
dv/binary_to_decimal_ascii_unit_tb.sv
